// File: rtl/rmvc_pkg.sv
// Shared constants, types and check tables for the rotation matrix validity checker.
// Used by every module under rtl; depends on nothing else.
package rmvc_pkg;

    // Element format and configuration width.
    localparam int ElemWidth = 18;
    localparam int FracBits  = 16;
    localparam int TolWidth  = 17;
    localparam int TolReset  = 655;

    // Pipeline stage numbers.
    localparam int NumStages = 5;
    localparam int StgProd   = 0;
    localparam int StgSum    = 1;
    localparam int StgCmp    = 2;
    localparam int StgAlign  = 3;
    localparam int StgOut    = 4;

    // Row checks, in priority order.
    localparam int NumRowChecks = 6;
    localparam int ChkOrth01    = 0;
    localparam int ChkOrth02    = 1;
    localparam int ChkOrth12    = 2;
    localparam int ChkNorm0     = 3;
    localparam int ChkNorm1     = 4;
    localparam int ChkNorm2     = 5;

    // Rows taken into each dot product; the norm checks use a row twice.
    localparam int RowA [NumRowChecks] = '{0, 0, 1, 0, 1, 2};
    localparam int RowB [NumRowChecks] = '{1, 2, 2, 0, 1, 2};

    // Determinant terms over flat element indices (row * 3 + column).
    // The first NumPosTerms are added, the rest subtracted.
    localparam int NumTerms    = 6;
    localparam int NumPosTerms = 3;
    localparam int TermA [NumTerms] = '{0, 1, 2, 0, 1, 2};
    localparam int TermB [NumTerms] = '{4, 5, 3, 5, 3, 4};
    localparam int TermC [NumTerms] = '{8, 6, 7, 7, 8, 6};

    // Row test widths: exact dot products at scale 2^(2F).
    localparam int ProdWidth   = 2 * ElemWidth;
    localparam int DotWidth    = ProdWidth + 2;
    localparam int RowDevWidth = ((DotWidth > 2 * FracBits + 2) ?
                                  DotWidth : 2 * FracBits + 2) + 1;
    localparam int RowTolWidth = TolWidth + FracBits;
    localparam int RowCmpWidth = (RowDevWidth > RowTolWidth) ? RowDevWidth : RowTolWidth;

    // Determinant widths: exact triple products at scale 2^(3F).
    localparam int TripleWidth = 3 * ElemWidth;
    localparam int PartWidth   = TripleWidth + 2;
    localparam int DetDevWidth = ((PartWidth + 1 > 3 * FracBits + 2) ?
                                  PartWidth + 1 : 3 * FracBits + 2) + 1;
    localparam int DetTolWidth = TolWidth + 2 * FracBits;
    localparam int DetCmpWidth = (DetDevWidth > DetTolWidth) ? DetDevWidth : DetTolWidth;

    // One at the scale of each test.
    localparam logic signed [RowDevWidth-1:0] RowOne = RowDevWidth'(1) << (2 * FracBits);
    localparam logic signed [DetDevWidth-1:0] DetOne = DetDevWidth'(1) << (3 * FracBits);

    typedef logic [ElemWidth-1:0] elem_t;
    typedef elem_t [8:0]          matrix_t;
    typedef logic [TolWidth-1:0]  tol_t;

    // Stage load enables and occupancy, sent from the control to the datapath.
    typedef struct packed {
        logic [NumStages-1:0] load;
        logic [NumStages-1:0] valid;
    } pipe_ctrl_t;

    typedef enum logic [2:0] {
        FailNone   = 3'd0,
        FailOrth01 = 3'd1,
        FailOrth02 = 3'd2,
        FailOrth12 = 3'd3,
        FailNorm0  = 3'd4,
        FailNorm1  = 3'd5,
        FailNorm2  = 3'd6,
        FailDet    = 3'd7
    } fail_code_t;

endpackage

// File: rtl/rmvc_pipe_ctrl.sv
// Valid bits and stage load enables for the five-stage checker pipeline.
// Depends on rmvc_pkg.
module rmvc_pipe_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    output rmvc_pkg::pipe_ctrl_t ctrl
);
    import rmvc_pkg::*;

    logic [NumStages-1:0] valid_reg;
    logic [NumStages-1:0] valid_next;
    logic [NumStages-1:0] ready;
    logic                 in_acc;
    logic                 out_acc;

    // A stage may load when it is empty or its contents move on, so bubbles close up.
    always_comb
    begin
        ready[NumStages-1] = !valid_reg[NumStages-1] || !out_stall;
        for (int s = NumStages - 2; s >= 0; s--)
        begin
            ready[s] = !valid_reg[s] || ready[s + 1];
        end
    end

    // Each loading stage takes the valid bit of the stage before it.
    always_comb
    begin
        valid_next = valid_reg;
        if (ready[0])
        begin
            valid_next[0] = in_valid;
        end
        for (int s = 1; s < NumStages; s++)
        begin
            if (ready[s])
            begin
                valid_next[s] = valid_reg[s - 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_stall   = !ready[0];
    assign out_valid  = valid_reg[NumStages-1];
    assign ctrl.load  = ready;
    assign ctrl.valid = valid_reg;
    assign in_acc     = in_valid && !in_stall;
    assign out_acc    = out_valid && !out_stall;

    // The input is held off only when every stage holds a beat.
    assert property (@(posedge clk) disable iff (!rst_n) in_stall |-> (&valid_reg))
        else $error("input stalled while the pipeline has a free stage");

    // Beats in flight change only by the beats accepted and delivered.
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ($countones(valid_reg) == $past($countones(valid_reg))
                  + int'($past(in_acc)) - int'($past(out_acc))))
        else $error("beat lost or duplicated inside the pipeline");

endmodule

// File: rtl/rmvc_row_check.sv
// Row orthogonality and unit norm tests: products, dot sums, tolerance compare.
// Depends on rmvc_pkg; stage loads come from rmvc_pipe_ctrl.
module rmvc_row_check (
    input  logic                                  clk,
    input  rmvc_pkg::pipe_ctrl_t                  ctrl,
    input  rmvc_pkg::matrix_t                     mat,
    input  rmvc_pkg::tol_t                        tol,
    output logic [rmvc_pkg::NumRowChecks-1:0]     row_fail
);
    import rmvc_pkg::*;

    logic signed [ProdWidth-1:0]   prod_reg  [NumRowChecks][3];
    logic signed [ProdWidth-1:0]   prod_next [NumRowChecks][3];
    logic signed [RowDevWidth-1:0] dev_reg   [NumRowChecks];
    logic signed [RowDevWidth-1:0] dev_next  [NumRowChecks];
    logic [RowDevWidth-1:0]        mag       [NumRowChecks];
    logic [RowCmpWidth-1:0]        tol_row;
    logic [NumRowChecks-1:0]       fail_next;
    logic [NumRowChecks-1:0]       fail_reg;
    logic [NumRowChecks-1:0]       align_reg;

    // Stage 1: the eighteen element products of the six dot products.
    always_comb
    begin
        for (int k = 0; k < NumRowChecks; k++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod_next[k][c] = ProdWidth'($signed(mat[3 * RowA[k] + c]))
                                * ProdWidth'($signed(mat[3 * RowB[k] + c]));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[StgProd])
        begin
            prod_reg <= prod_next;
        end
    end

    // Stage 2: dot sums; the norm checks take one away.
    always_comb
    begin
        for (int k = 0; k < NumRowChecks; k++)
        begin
            dev_next[k] = RowDevWidth'(prod_reg[k][0]) + RowDevWidth'(prod_reg[k][1])
                        + RowDevWidth'(prod_reg[k][2]);
            if (k >= ChkNorm0)
            begin
                dev_next[k] = dev_next[k] - RowOne;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[StgSum])
        begin
            dev_reg <= dev_next;
        end
    end

    // Stage 3: a deviation above the tolerance fails; equal passes.
    assign tol_row = RowCmpWidth'({tol, {FracBits{1'b0}}});

    always_comb
    begin
        for (int k = 0; k < NumRowChecks; k++)
        begin
            mag[k] = dev_reg[k][RowDevWidth-1] ? RowDevWidth'(-dev_reg[k])
                                               : RowDevWidth'(dev_reg[k]);
            fail_next[k] = RowCmpWidth'(mag[k]) > tol_row;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[StgCmp])
        begin
            fail_reg <= fail_next;
        end
    end

    // Stage 4: hold the results level with the determinant path.
    always_ff @(posedge clk)
    begin
        if (ctrl.load[StgAlign])
        begin
            align_reg <= fail_reg;
        end
    end

    assign row_fail = align_reg;

endmodule

// File: rtl/rmvc_det_check.sv
// Determinant test: pair products, triple products, partial sums, deviation from one.
// Depends on rmvc_pkg; stage loads come from rmvc_pipe_ctrl.
module rmvc_det_check (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rmvc_pkg::pipe_ctrl_t ctrl,
    input  rmvc_pkg::matrix_t    mat,
    input  rmvc_pkg::tol_t       tol,
    output logic                 det_fail
);
    import rmvc_pkg::*;

    logic signed [ProdWidth-1:0]   pair_reg   [NumTerms];
    logic signed [ProdWidth-1:0]   pair_next  [NumTerms];
    logic signed [ElemWidth-1:0]   third_reg  [NumTerms];
    logic signed [ElemWidth-1:0]   third_next [NumTerms];
    logic signed [TripleWidth-1:0] trip_reg   [NumTerms];
    logic signed [TripleWidth-1:0] trip_next  [NumTerms];
    logic signed [PartWidth-1:0]   pos_reg;
    logic signed [PartWidth-1:0]   pos_next;
    logic signed [PartWidth-1:0]   neg_reg;
    logic signed [PartWidth-1:0]   neg_next;
    logic signed [DetDevWidth-1:0] dev_reg;
    logic signed [DetDevWidth-1:0] dev_next;
    logic [DetDevWidth-1:0]        mag;
    logic [DetCmpWidth-1:0]        tol_det;

    // Stage 1: first product of each term; the third factor travels alongside.
    always_comb
    begin
        for (int t = 0; t < NumTerms; t++)
        begin
            pair_next[t]  = ProdWidth'($signed(mat[TermA[t]]))
                          * ProdWidth'($signed(mat[TermB[t]]));
            third_next[t] = $signed(mat[TermC[t]]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[StgProd])
        begin
            pair_reg  <= pair_next;
            third_reg <= third_next;
        end
    end

    // Stage 2: full triple products.
    always_comb
    begin
        for (int t = 0; t < NumTerms; t++)
        begin
            trip_next[t] = TripleWidth'(pair_reg[t]) * TripleWidth'(third_reg[t]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[StgSum])
        begin
            trip_reg <= trip_next;
        end
    end

    // Stage 3: sums of the added and of the subtracted terms.
    always_comb
    begin
        pos_next = '0;
        neg_next = '0;
        for (int t = 0; t < NumTerms; t++)
        begin
            if (t < NumPosTerms)
            begin
                pos_next = pos_next + PartWidth'(trip_reg[t]);
            end
            else
            begin
                neg_next = neg_next + PartWidth'(trip_reg[t]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[StgCmp])
        begin
            pos_reg <= pos_next;
            neg_reg <= neg_next;
        end
    end

    // Stage 4: signed deviation of the determinant from one.
    assign dev_next = DetDevWidth'(pos_reg) - DetDevWidth'(neg_reg) - DetOne;

    always_ff @(posedge clk)
    begin
        if (ctrl.load[StgAlign])
        begin
            dev_reg <= dev_next;
        end
    end

    // A deviation equal to the tolerance already fails here.
    assign tol_det  = DetCmpWidth'({tol, {(2 * FracBits){1'b0}}});
    assign mag      = dev_reg[DetDevWidth-1] ? DetDevWidth'(-dev_reg) : DetDevWidth'(dev_reg);
    assign det_fail = DetCmpWidth'(mag) >= tol_det;

    // With no tolerance at all the determinant test can never pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.valid[StgAlign] && (tol == '0)) |-> det_fail)
        else $error("determinant passed with zero tolerance");

endmodule

// File: rtl/rotation_matrix_validity_check_top.sv
// Top level of the 3x3 rotation matrix validity checker: tolerance register,
// result encoding and output register. Depends on rmvc_pkg, rmvc_pipe_ctrl,
// rmvc_row_check and rmvc_det_check.
//
//  Channel  | Handshake                 | Payload
//  ---------+---------------------------+------------------------------------
//  input    | in_valid / in_stall       | m00 .. m22, signed Q2.16
//  output   | out_valid / out_stall     | is_valid, first_failure
//  config   | cfg_wr_en                 | cfg_wr_data, tolerance in unsigned Q1.16
//
// One matrix is accepted every cycle while in_stall is low; each result passes
// through the five register stages of the multiplier pipeline
// (pair products, triple products and dot sums, partial sums and compares,
// determinant deviation, output register).
// Reset empties the pipeline and sets the tolerance to 655; there is no clearing pass.
// A stalled output holds the last stage only; earlier stages keep filling any
// empty stage, and the input is stalled only when all five stages hold a beat.
module rotation_matrix_validity_check_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  rmvc_pkg::elem_t     m00,
    input  rmvc_pkg::elem_t     m01,
    input  rmvc_pkg::elem_t     m02,
    input  rmvc_pkg::elem_t     m10,
    input  rmvc_pkg::elem_t     m11,
    input  rmvc_pkg::elem_t     m12,
    input  rmvc_pkg::elem_t     m20,
    input  rmvc_pkg::elem_t     m21,
    input  rmvc_pkg::elem_t     m22,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                is_valid,
    output logic [2:0]          first_failure,
    input  logic                cfg_wr_en,
    input  rmvc_pkg::tol_t      cfg_wr_data
);
    import rmvc_pkg::*;

    pipe_ctrl_t              ctrl;
    matrix_t                 mat;
    tol_t                    tol_reg;
    logic [NumRowChecks-1:0] row_fail;
    logic                    det_fail;
    fail_code_t              code_next;
    fail_code_t              code_reg;
    logic                    is_valid_reg;

    // Flat element order is row * 3 + column.
    assign mat = {m22, m21, m20, m12, m11, m10, m02, m01, m00};

    // Tolerance register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TolWidth'(TolReset);
        end
        else if (cfg_wr_en)
        begin
            tol_reg <= cfg_wr_data;
        end
    end

    rmvc_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctrl      (ctrl)
    );

    rmvc_row_check u_row (
        .clk      (clk),
        .ctrl     (ctrl),
        .mat      (mat),
        .tol      (tol_reg),
        .row_fail (row_fail)
    );

    rmvc_det_check u_det (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .mat      (mat),
        .tol      (tol_reg),
        .det_fail (det_fail)
    );

    // First failing check wins; the determinant counts only when every row test passed.
    always_comb
    begin
        if (row_fail[ChkOrth01])
        begin
            code_next = FailOrth01;
        end
        else if (row_fail[ChkOrth02])
        begin
            code_next = FailOrth02;
        end
        else if (row_fail[ChkOrth12])
        begin
            code_next = FailOrth12;
        end
        else if (row_fail[ChkNorm0])
        begin
            code_next = FailNorm0;
        end
        else if (row_fail[ChkNorm1])
        begin
            code_next = FailNorm1;
        end
        else if (row_fail[ChkNorm2])
        begin
            code_next = FailNorm2;
        end
        else if (det_fail)
        begin
            code_next = FailDet;
        end
        else
        begin
            code_next = FailNone;
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (ctrl.load[StgOut])
        begin
            code_reg     <= code_next;
            is_valid_reg <= (code_next == FailNone);
        end
    end

    assign is_valid      = is_valid_reg;
    assign first_failure = code_reg;

    // The pass flag and the failure code must agree on every delivered beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_valid == (first_failure == FailNone)))
        else $error("pass flag disagrees with failure code");

endmodule
